FILE: src/price_time_order_matcher_assert.svh
// Assertion macros used by the order matcher RTL.
`ifndef PRICE_TIME_ORDER_MATCHER_ASSERT_SVH
`define PRICE_TIME_ORDER_MATCHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTOM_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("order matcher assertion failed");

// Next-cycle implication checked outside reset.
`define PTOM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("order matcher assertion failed");

`endif

FILE: src/ptom_pkg.sv
// Shared types and constants of the order matcher.
package ptom_pkg;

    localparam int FILL_CAP = 64;
    localparam int FILL_CNT_W = 7;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [15:0] price;
        logic [31:0] quantity;
        logic [31:0] id;
        logic [31:0] arrival;
    } slot_t;

    typedef struct packed {
        logic        found;
        logic [15:0] price;
        logic [31:0] quantity;
        logic [31:0] id;
        logic [31:0] arrival;
    } best_t;

    // True when arrival a lies behind b modulo 2^32.
    function automatic logic is_older(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

FILE: src/ptom_book_mem.sv
// Book memory: one write port, one registered read port.
module ptom_book_mem import ptom_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ptom_scan.sv
// Book scanner: best bid, best ask and first free slot of each table.
module ptom_scan import ptom_pkg::*; #(
    parameter int ORDER_SLOTS = 64,
    parameter int AW = 7
) (
    input  logic          aclk,
    input  logic          clr,
    input  logic          beat,
    input  logic [AW-1:0] beat_idx,
    input  slot_t         beat_slot,
    output best_t         bid,
    output best_t         ask,
    output logic [AW-1:0] bid_idx,
    output logic [AW-1:0] ask_idx,
    output logic          free_bid_found,
    output logic          free_ask_found,
    output logic [AW-1:0] free_bid_idx,
    output logic [AW-1:0] free_ask_idx
);

    localparam logic [AW-1:0] SPLIT = AW'(ORDER_SLOTS);

    best_t         bid_reg, bid_next, ask_reg, ask_next, cand;
    logic [AW-1:0] bid_idx_reg, bid_idx_next, ask_idx_reg, ask_idx_next;
    logic          fb_reg, fb_next, fa_reg, fa_next;
    logic [AW-1:0] fbi_reg, fbi_next, fai_reg, fai_next;
    logic          in_ask;

    always_comb begin
        in_ask = beat_idx >= SPLIT;
        cand = '{found: 1'b1, price: beat_slot.price, quantity: beat_slot.quantity,
                 id: beat_slot.id, arrival: beat_slot.arrival};
        bid_next = bid_reg;
        ask_next = ask_reg;
        bid_idx_next = bid_idx_reg;
        ask_idx_next = ask_idx_reg;
        fb_next = fb_reg;
        fa_next = fa_reg;
        fbi_next = fbi_reg;
        fai_next = fai_reg;
        if (clr) begin
            bid_next.found = 1'b0;
            ask_next.found = 1'b0;
            fb_next = 1'b0;
            fa_next = 1'b0;
        end else if (beat) begin
            if (beat_slot.valid && !in_ask) begin
                if (!bid_reg.found || beat_slot.price > bid_reg.price
                    || (beat_slot.price == bid_reg.price
                        && is_older(beat_slot.arrival, bid_reg.arrival))) begin
                    bid_next = cand;
                    bid_idx_next = beat_idx;
                end
            end
            if (beat_slot.valid && in_ask) begin
                if (!ask_reg.found || beat_slot.price < ask_reg.price
                    || (beat_slot.price == ask_reg.price
                        && is_older(beat_slot.arrival, ask_reg.arrival))) begin
                    ask_next = cand;
                    ask_idx_next = beat_idx;
                end
            end
            if (!beat_slot.valid && !in_ask && !fb_reg) begin
                fb_next = 1'b1;
                fbi_next = beat_idx;
            end
            if (!beat_slot.valid && in_ask && !fa_reg) begin
                fa_next = 1'b1;
                fai_next = beat_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bid_reg <= bid_next;
        ask_reg <= ask_next;
        bid_idx_reg <= bid_idx_next;
        ask_idx_reg <= ask_idx_next;
        fb_reg <= fb_next;
        fa_reg <= fa_next;
        fbi_reg <= fbi_next;
        fai_reg <= fai_next;
    end

    assign bid = bid_reg;
    assign ask = ask_reg;
    assign bid_idx = bid_idx_reg;
    assign ask_idx = ask_idx_reg;
    assign free_bid_found = fb_reg;
    assign free_ask_found = fa_reg;
    assign free_bid_idx = fbi_reg;
    assign free_ask_idx = fai_reg;

endmodule

FILE: src/price_time_order_matcher.sv
// Price-time priority matcher: the bid and ask tables share one book memory of
// 2*ORDER_SLOTS entries, and every decision comes from a full scan of that memory,
// one entry per cycle. After reset a clearing pass writes every entry before the
// first request is taken. A request costs one scan to find free slots and the
// book's top; a rested order costs one more scan, and every fill adds a write of
// the bid entry and of the ask entry, one more scan and an output step. The output
// register lets the last result wait while the next request is taken; a further
// result waits for the previous one to be taken.
module price_time_order_matcher import ptom_pkg::*; #(
    parameter int ORDER_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_order_side,
    input  logic [15:0] s_order_price,
    input  logic [31:0] s_order_quantity,
    input  logic [31:0] s_order_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [31:0] m_buyer_id,
    output logic [31:0] m_seller_id,
    output logic [15:0] m_fill_price,
    output logic [31:0] m_fill_quantity,
    output logic [15:0] m_top_bid,
    output logic [15:0] m_top_ask,
    output logic        m_last
);

`include "price_time_order_matcher_assert.svh"

    localparam int DEPTH = 2 * ORDER_SLOTS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_END = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);
    localparam logic [FILL_CNT_W-1:0] CAP = FILL_CNT_W'(FILL_CAP);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_DONE, ST_INSERT, ST_FILL_B, ST_FILL_A, ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  beat_reg;
    logic [AW-1:0]         beat_idx_reg;
    logic                  pre_reg;
    logic                  pending_reg;
    logic                  more_reg;
    logic [FILL_CNT_W-1:0] n_reg;
    logic [31:0]           arrival_reg;
    logic                  ord_side_reg;
    logic [15:0]           ord_price_reg;
    logic [31:0]           ord_qty_reg;
    logic [31:0]           ord_id_reg;
    logic                  tr_kind_reg;
    logic [31:0]           tr_buyer_reg;
    logic [31:0]           tr_seller_reg;
    logic [15:0]           tr_price_reg;
    logic [31:0]           tr_qty_reg;
    logic                  m_valid_reg, m_kind_reg, m_last_reg;
    logic [31:0]           m_buyer_reg, m_seller_reg, m_qty_reg;
    logic [15:0]           m_price_reg, m_top_bid_reg, m_top_ask_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata, mem_rdata;
    best_t         bid, ask;
    logic [AW-1:0] bid_idx, ask_idx, free_bid_idx, free_ask_idx;
    logic          free_bid_found, free_ask_found;
    logic          crossed, more, side_free;
    logic [31:0]   fill_q, bid_rest, ask_rest;

    ptom_book_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    ptom_scan #(.ORDER_SLOTS(ORDER_SLOTS), .AW(AW)) u_scan (
        .aclk           (aclk),
        .clr            (state_reg == ST_SCAN && cnt_reg == '0),
        .beat           (beat_reg),
        .beat_idx       (beat_idx_reg),
        .beat_slot      (mem_rdata),
        .bid            (bid),
        .ask            (ask),
        .bid_idx        (bid_idx),
        .ask_idx        (ask_idx),
        .free_bid_found (free_bid_found),
        .free_ask_found (free_ask_found),
        .free_bid_idx   (free_bid_idx),
        .free_ask_idx   (free_ask_idx)
    );

    always_comb begin
        crossed = bid.found && ask.found && (bid.price >= ask.price);
        more = crossed && (n_reg < CAP);
        side_free = ord_side_reg ? free_ask_found : free_bid_found;
        fill_q = (bid.quantity < ask.quantity) ? bid.quantity : ask.quantity;
        bid_rest = bid.quantity - fill_q;
        ask_rest = ask.quantity - tr_qty_reg;
        mem_we = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_INSERT: begin
                mem_we = 1'b1;
                mem_waddr = ord_side_reg ? free_ask_idx : free_bid_idx;
                mem_wdata = '{valid: 1'b1, price: ord_price_reg, quantity: ord_qty_reg,
                              id: ord_id_reg, arrival: arrival_reg};
            end
            ST_FILL_B: begin
                mem_we = 1'b1;
                mem_waddr = bid_idx;
                mem_wdata = '{valid: bid_rest != 32'd0, price: bid.price, quantity: bid_rest,
                              id: bid.id, arrival: bid.arrival};
            end
            ST_FILL_A: begin
                mem_we = 1'b1;
                mem_waddr = ask_idx;
                mem_wdata = '{valid: ask_rest != 32'd0, price: ask.price, quantity: ask_rest,
                              id: ask.id, arrival: ask.arrival};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            beat_reg <= 1'b0;
            arrival_reg <= '0;
            m_valid_reg <= 1'b0;
            n_reg <= '0;
            pre_reg <= 1'b0;
            pending_reg <= 1'b0;
            more_reg <= 1'b0;
        end else begin
            beat_reg <= 1'b0;
            // The emit state loads the output register itself.
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ord_side_reg <= s_order_side;
                        ord_price_reg <= s_order_price;
                        ord_qty_reg <= s_order_quantity;
                        ord_id_reg <= s_order_id;
                        pre_reg <= 1'b1;
                        cnt_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Read data arrives in the cycle after its address is given.
                    beat_reg <= cnt_reg != CNT_END;
                    beat_idx_reg <= cnt_reg[AW-1:0];
                    if (cnt_reg == CNT_END) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (pre_reg) begin
                        if (ord_qty_reg == 32'd0 || !side_free) begin
                            tr_kind_reg <= KIND_REJECT;
                            tr_buyer_reg <= (ord_side_reg == SIDE_SELL) ? 32'd0 : ord_id_reg;
                            tr_seller_reg <= (ord_side_reg == SIDE_SELL) ? ord_id_reg : 32'd0;
                            tr_price_reg <= '0;
                            tr_qty_reg <= '0;
                            more_reg <= 1'b0;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_INSERT;
                        end
                    end else if (pending_reg) begin
                        more_reg <= more;
                        state_reg <= ST_EMIT;
                    end else if (crossed) begin
                        state_reg <= ST_FILL_B;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INSERT: begin
                    arrival_reg <= arrival_reg + 32'd1;
                    pre_reg <= 1'b0;
                    pending_reg <= 1'b0;
                    n_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_FILL_B: begin
                    tr_kind_reg <= KIND_TRADE;
                    tr_buyer_reg <= bid.id;
                    tr_seller_reg <= ask.id;
                    tr_price_reg <= ask.price;
                    tr_qty_reg <= fill_q;
                    n_reg <= n_reg + 1'b1;
                    pending_reg <= 1'b1;
                    state_reg <= ST_FILL_A;
                end
                ST_FILL_A: begin
                    cnt_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg <= tr_kind_reg;
                        m_buyer_reg <= tr_buyer_reg;
                        m_seller_reg <= tr_seller_reg;
                        m_price_reg <= tr_price_reg;
                        m_qty_reg <= tr_qty_reg;
                        m_top_bid_reg <= bid.found ? bid.price : 16'd0;
                        m_top_ask_reg <= ask.found ? ask.price : 16'd0;
                        m_last_reg <= !more_reg;
                        state_reg <= more_reg ? ST_FILL_B : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_kind = m_kind_reg;
    assign m_buyer_id = m_buyer_reg;
    assign m_seller_id = m_seller_reg;
    assign m_fill_price = m_price_reg;
    assign m_fill_quantity = m_qty_reg;
    assign m_top_bid = m_top_bid_reg;
    assign m_top_ask = m_top_ask_reg;
    assign m_last = m_last_reg;

    `PTOM_ASSERT_IMPLY(a_fill_cap, 1'b1, n_reg <= CAP)
    `PTOM_ASSERT_IMPLY(a_trade_nonzero, m_valid && m_kind == KIND_TRADE, m_fill_quantity != 32'd0)
    `PTOM_ASSERT_NEXT(a_insert_rescans, state_reg == ST_INSERT, state_reg == ST_SCAN && cnt_reg == '0)
    `PTOM_ASSERT_IMPLY(a_fill_crossed, state_reg == ST_FILL_B, crossed)

endmodule

FILE: verif/tb_price_time_order_matcher.sv
// Self-checking testbench of the price-time priority order matcher.
module tb_price_time_order_matcher import ptom_pkg::*; ();

    localparam int SLOTS = 64;
    localparam int DRAIN_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic        kind;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] fill_price;
        logic [31:0] fill_quantity;
        logic [15:0] top_bid;
        logic [15:0] top_ask;
        logic        last;
    } trade_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_order_side = 1'b0;
    logic [15:0] s_order_price = '0;
    logic [31:0] s_order_quantity = '0;
    logic [31:0] s_order_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [31:0] m_buyer_id;
    logic [31:0] m_seller_id;
    logic [15:0] m_fill_price;
    logic [31:0] m_fill_quantity;
    logic [15:0] m_top_bid;
    logic [15:0] m_top_ask;
    logic        m_last;

    price_time_order_matcher #(.ORDER_SLOTS(SLOTS)) u_dut (.*);

    // Shadow copy of the order book.
    logic        book_valid [2*SLOTS];
    logic [15:0] book_price [2*SLOTS];
    logic [31:0] book_qty   [2*SLOTS];
    logic [31:0] book_id    [2*SLOTS];
    logic [31:0] book_seq   [2*SLOTS];
    logic [31:0] seq_count;

    trade_rec_t pending_trades[$];
    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    longint cycle_count = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("price_time_order_matcher: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic seq_behind(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return (d != 0) && (d < 32'h8000_0000);
    endfunction

    function automatic int best_index(logic side);
        int found;
        int base;
        found = -1;
        base = (side == SIDE_SELL) ? SLOTS : 0;
        for (int i = base; i < base + SLOTS; i++) begin
            if (!book_valid[i]) continue;
            if (found < 0) found = i;
            else if (book_price[i] != book_price[found]) begin
                if ((side == SIDE_SELL) ? (book_price[i] < book_price[found])
                                        : (book_price[i] > book_price[found]))
                    found = i;
            end else if (seq_behind(book_seq[i], book_seq[found])) found = i;
        end
        return found;
    endfunction

    function automatic logic [15:0] top_of(logic side);
        int s;
        s = best_index(side);
        return (s < 0) ? 16'd0 : book_price[s];
    endfunction

    // Updates the shadow book for one accepted request and queues its results.
    task automatic book_order(logic side, logic [15:0] price, logic [31:0] qty,
                              logic [31:0] id);
        int free_idx;
        int base;
        int fills;
        int b;
        int a;
        logic [31:0] q;
        trade_rec_t r;
        free_idx = -1;
        fills = 0;
        base = (side == SIDE_SELL) ? SLOTS : 0;
        for (int i = base; i < base + SLOTS; i++)
            if (!book_valid[i] && free_idx < 0) free_idx = i;
        if (qty == 0 || free_idx < 0) begin
            r.kind = KIND_REJECT;
            r.buyer_id = (side == SIDE_SELL) ? 32'd0 : id;
            r.seller_id = (side == SIDE_SELL) ? id : 32'd0;
            r.fill_price = '0;
            r.fill_quantity = '0;
            r.top_bid = top_of(SIDE_BUY);
            r.top_ask = top_of(SIDE_SELL);
            r.last = 1'b1;
            pending_trades = {pending_trades, r};
            return;
        end
        book_valid[free_idx] = 1'b1;
        book_price[free_idx] = price;
        book_qty[free_idx] = qty;
        book_id[free_idx] = id;
        book_seq[free_idx] = seq_count;
        seq_count++;
        while (fills < FILL_CAP) begin
            b = best_index(SIDE_BUY);
            a = best_index(SIDE_SELL);
            if (b < 0 || a < 0 || book_price[b] < book_price[a]) break;
            q = (book_qty[b] < book_qty[a]) ? book_qty[b] : book_qty[a];
            r.kind = KIND_TRADE;
            r.buyer_id = book_id[b];
            r.seller_id = book_id[a];
            r.fill_price = book_price[a];
            r.fill_quantity = q;
            book_qty[b] -= q;
            book_qty[a] -= q;
            if (book_qty[b] == 0) book_valid[b] = 1'b0;
            if (book_qty[a] == 0) book_valid[a] = 1'b0;
            r.top_bid = top_of(SIDE_BUY);
            r.top_ask = top_of(SIDE_SELL);
            r.last = 1'b0;
            pending_trades = {pending_trades, r};
            fills++;
        end
        if (fills > 0) pending_trades[$].last = 1'b1;
    endtask

    // Offers one request; valid is only lowered when an idle gap follows.
    task automatic send_order(logic side, logic [15:0] price, logic [31:0] qty,
                              logic [31:0] id);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_order_side <= side;
        s_order_price <= price;
        s_order_quantity <= qty;
        s_order_id <= id;
        do @(posedge aclk); while (!s_ready);
        book_order(side, price, qty, id);
    endtask

    task automatic wait_book_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_trades.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        trade_rec_t got;
        trade_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_buyer_id, m_seller_id, m_fill_price, m_fill_quantity,
                   m_top_bid, m_top_ask, m_last};
            if (pending_trades.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = pending_trades.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_edges();
        send_order(SIDE_BUY, 16'd0, 32'd5, 32'hFFFF_FFFF);
        send_order(SIDE_SELL, 16'hFFFF, 32'd7, 32'h0000_0001);
        send_order(SIDE_BUY, 16'd100, 32'd0, 32'h1234_5678);
        send_order(SIDE_SELL, 16'd100, 32'd0, 32'h8765_4321);
        send_order(SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_order(SIDE_SELL, 16'd0, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        // Two bids at one price: the older one must trade first.
        send_order(SIDE_BUY, 16'd500, 32'd10, 32'd11);
        send_order(SIDE_BUY, 16'd500, 32'd10, 32'd12);
        send_order(SIDE_BUY, 16'd400, 32'd10, 32'd13);
        send_order(SIDE_SELL, 16'd450, 32'd15, 32'd21);
        send_order(SIDE_SELL, 16'd300, 32'd30, 32'd22);
        send_order(SIDE_SELL, 16'd0, 32'd3, 32'd23);
        send_order(SIDE_BUY, 16'd0, 32'd1, 32'd24);
        send_order(SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, 32'd25);
        send_order(SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'd26);
        wait_book_idle();
    endtask

    // Fills the bid table until it rejects, then sweeps it with one sell.
    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_order(SIDE_BUY, 16'(10 + i), 32'(1 + i), 32'(1000 + i));
        send_order(SIDE_SELL, 16'd0, 32'hFFFF_FFFF, 32'd2000);
        send_order(SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, 32'd2001);
        send_order(SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'd2002);
        wait_book_idle();
    endtask

    task automatic send_random(int count);
        logic [15:0] p;
        logic [31:0] q;
        for (int i = 0; i < count; i++) begin
            p = 16'(1000 + $urandom_range(40) - 20);
            q = 32'($urandom_range(1, 50));
            case ($urandom_range(19))
                0: q = 32'd0;
                1: p = 16'($urandom);
                2: q = $urandom;
                3: p = $urandom_range(1) ? 16'hFFFF : 16'd0;
                default: ;
            endcase
            send_order(1'($urandom), p, q, $urandom);
        end
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 4000;
        for (int i = 0; i < 12; i++)
            send_order(1'(i[0]), 16'd1000, 32'd5, 32'(3000 + i));
        wait_book_idle();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(85);
        send_idle_pct = 84; recv_stall_pct = 0;  send_random(85);
        send_idle_pct = 0;  recv_stall_pct = 84; send_random(85);
        send_idle_pct = 35; recv_stall_pct = 35; send_random(85);
        wait_book_idle();
    endtask

    initial begin
        for (int i = 0; i < 2*SLOTS; i++) begin
            book_valid[i] = 1'b0;
            book_price[i] = '0;
            book_qty[i] = '0;
            book_id[i] = '0;
            book_seq[i] = '0;
        end
        seq_count = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_edges();
        test_table_full();
        test_back_pressure();
        test_random_phases();
        if (fail_count == 0 && pending_trades.size() == 0) begin
            $display("price_time_order_matcher: match");
        end else begin
            $display("price_time_order_matcher: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/ptom_pkg.sv
src/ptom_book_mem.sv
src/ptom_scan.sv
src/price_time_order_matcher.sv
verif/tb_price_time_order_matcher.sv
